/* rtl/emh_pkg.sv */
`default_nettype none

package emh_pkg;

  localparam logic [31:0] SEED_RESET = 32'h0DEA_DBEF;
  localparam logic [31:0] MIX_C1     = 32'hcc9e_2d51;
  localparam logic [31:0] MIX_C2     = 32'h1b87_3593;
  localparam logic [31:0] MIX_N      = 32'he654_6b64;
  localparam logic [31:0] FIN_M1     = 32'h85eb_ca6b;
  localparam logic [31:0] FIN_M2     = 32'hc2b2_ae35;
  localparam logic [31:0] LEN_V4     = 32'd6;
  localparam logic [31:0] LEN_V6     = 32'd18;

  localparam logic [1:0] FAM_V4 = 2'd0;
  localparam logic [1:0] FAM_V6 = 2'd1;

  localparam int unsigned PC_W = 3;

  typedef struct packed {
    logic [1:0]  family;
    logic [63:0] address_high;
    logic [63:0] address_low;
    logic [15:0] port;
  } in_item_t;

  typedef struct packed {
    logic [31:0] hash;
    logic        valid_res;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_K_C1,
    OP_K_C2,
    OP_H_ABS,
    OP_H_M1,
    OP_H_M2,
    OP_DONE
  } op_t;

  typedef enum logic {
    COND_NONE,
    COND_MORE_BLK
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [PC_W-1:0]  target;
  } uword_t;

  typedef struct packed {
    logic load;
    logic run;
    op_t  op;
  } dp_ctrl_t;

  typedef struct packed {
    logic        more_blk;
    logic [31:0] fin_hash;
  } dp_stat_t;

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{op: OP_DONE, cond: COND_NONE, target: '0};
    unique case (pc)
      3'd0: w = '{op: OP_K_C1,  cond: COND_NONE,     target: 3'd0};
      3'd1: w = '{op: OP_K_C2,  cond: COND_NONE,     target: 3'd0};
      3'd2: w = '{op: OP_H_ABS, cond: COND_MORE_BLK, target: 3'd0};
      3'd3: w = '{op: OP_K_C1,  cond: COND_NONE,     target: 3'd0};
      3'd4: w = '{op: OP_K_C2,  cond: COND_NONE,     target: 3'd0};
      3'd5: w = '{op: OP_H_M1,  cond: COND_NONE,     target: 3'd0};
      3'd6: w = '{op: OP_H_M2,  cond: COND_NONE,     target: 3'd0};
      3'd7: w = '{op: OP_DONE,  cond: COND_NONE,     target: 3'd0};
      default: w = '{op: OP_DONE, cond: COND_NONE, target: 3'd0};
    endcase
    return w;
  endfunction

  function automatic logic [31:0] bswap32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

`default_nettype wire

/* rtl/endpoint_murmur3_hash_unit.sv */
`default_nettype none
// Channel  | Ports                               | Handshake
// input    | start, busy, in_data (in_item_t)    | accepted when start && !busy
// result   | out_strobe, out_data (out_item_t)   | one cycle, no back-pressure
// config   | cfg_we, cfg_wdata                   | seed_r written when cfg_we
//
// IPv4: one block round, then tail and finalization steps; IPv6: three extra
// block rounds of 3 steps. Unknown family: result strobe the cycle after accept.
// Each step is one microcode word; the single shared 32x32 multiplier sets
// the step count. busy is high while the sequencer runs; the result strobe
// coincides with busy falling, so start may be taken in that cycle.
// Synchronous active-low reset clears control and loads the seed.

module endpoint_murmur3_hash_unit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire emh_pkg::in_item_t in_data,
  output logic                   out_strobe,
  output emh_pkg::out_item_t     out_data,
  input  wire logic              cfg_we,
  input  wire logic [31:0]       cfg_wdata
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t                      state_r;
  logic [emh_pkg::PC_W-1:0]    pc_r;
  logic [31:0]                 seed_r;
  logic                        out_strobe_r;
  emh_pkg::out_item_t          out_data_r;

  emh_pkg::uword_t   uw;
  emh_pkg::dp_ctrl_t ctrl;
  emh_pkg::dp_stat_t stat;
  logic              accept, known;

  assign uw     = emh_pkg::ucode(pc_r);
  assign accept = start && (state_r == ST_IDLE);
  assign known  = (in_data.family == emh_pkg::FAM_V4) || (in_data.family == emh_pkg::FAM_V6);

  assign ctrl.load = accept && known;
  assign ctrl.run  = (state_r == ST_RUN);
  assign ctrl.op   = uw.op;

  emh_datapath u_dp (
    .clk  (clk),
    .ctrl (ctrl),
    .item (in_data),
    .seed (seed_r),
    .stat (stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pc_r         <= '0;
      seed_r       <= emh_pkg::SEED_RESET;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      if (cfg_we) begin
        seed_r <= cfg_wdata;
      end
      unique case (state_r)
        ST_IDLE: begin
          pc_r <= '0;
          if (accept && known) begin
            state_r <= ST_RUN;
          end else if (accept) begin
            out_strobe_r         <= 1'b1;
            out_data_r.hash      <= '0;
            out_data_r.valid_res <= 1'b0;
          end
        end
        ST_RUN: begin
          if (uw.op == emh_pkg::OP_DONE) begin
            state_r              <= ST_IDLE;
            pc_r                 <= '0;
            out_strobe_r         <= 1'b1;
            out_data_r.hash      <= stat.fin_hash;
            out_data_r.valid_res <= 1'b1;
          end else if (uw.cond == emh_pkg::COND_MORE_BLK && stat.more_blk) begin
            pc_r <= uw.target;
          end else begin
            pc_r <= pc_r + 1'b1;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy       = (state_r == ST_RUN);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe while sequencer busy");

  a_unknown_fam: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !known |=> out_strobe && !out_data.valid_res && out_data.hash == 32'd0)
    else $error("unknown family not answered with empty result");

  a_done_emits: assert property (@(posedge clk) disable iff (!rst_n)
    busy && uw.op == emh_pkg::OP_DONE |=> out_strobe && out_data.valid_res)
    else $error("final step did not emit a result");

  a_idle_pc: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> pc_r == '0)
    else $error("step counter not rewound at end of transaction");

endmodule

`default_nettype wire

/* rtl/emh_datapath.sv */
`default_nettype none

module emh_datapath (
  input  wire logic              clk,
  input  wire emh_pkg::dp_ctrl_t ctrl,
  input  wire emh_pkg::in_item_t item,
  input  wire logic [31:0]       seed,
  output emh_pkg::dp_stat_t      stat
);

  logic [31:0]      h_r, h_nxt;
  logic [31:0]      k_r, k_nxt;
  logic [3:0][31:0] q_r, q_nxt;
  logic [1:0]       blk_r, blk_nxt;
  logic             v6_r, v6_nxt;

  logic [31:0] mul_a, mul_b, mul_p;
  logic [31:0] abs_t, fin_x, len_w;

  assign len_w = v6_r ? emh_pkg::LEN_V6 : emh_pkg::LEN_V4;
  assign fin_x = h_r ^ k_r ^ len_w;
  assign abs_t = {h_r[18:0] ^ k_r[18:0], h_r[31:19] ^ k_r[31:19]};

  always_comb begin
    unique case (ctrl.op)
      emh_pkg::OP_K_C1: begin
        mul_a = k_r;
        mul_b = emh_pkg::MIX_C1;
      end
      emh_pkg::OP_K_C2: begin
        mul_a = {k_r[16:0], k_r[31:17]};
        mul_b = emh_pkg::MIX_C2;
      end
      emh_pkg::OP_H_M1: begin
        mul_a = fin_x ^ {16'd0, fin_x[31:16]};
        mul_b = emh_pkg::FIN_M1;
      end
      emh_pkg::OP_H_M2: begin
        mul_a = h_r ^ {13'd0, h_r[31:13]};
        mul_b = emh_pkg::FIN_M2;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    h_nxt   = h_r;
    k_nxt   = k_r;
    q_nxt   = q_r;
    blk_nxt = blk_r;
    v6_nxt  = v6_r;
    if (ctrl.load) begin
      h_nxt = seed;
      if (item.family == emh_pkg::FAM_V6) begin
        v6_nxt   = 1'b1;
        blk_nxt  = 2'd3;
        k_nxt    = emh_pkg::bswap32(item.address_high[63:32]);
        q_nxt[0] = emh_pkg::bswap32(item.address_high[31:0]);
        q_nxt[1] = emh_pkg::bswap32(item.address_low[63:32]);
        q_nxt[2] = emh_pkg::bswap32(item.address_low[31:0]);
        q_nxt[3] = {16'd0, item.port[7:0], item.port[15:8]};
      end else begin
        v6_nxt   = 1'b0;
        blk_nxt  = 2'd0;
        k_nxt    = emh_pkg::bswap32(item.address_low[31:0]);
        q_nxt[0] = {16'd0, item.port[7:0], item.port[15:8]};
        q_nxt[1] = '0;
        q_nxt[2] = '0;
        q_nxt[3] = '0;
      end
    end else if (ctrl.run) begin
      unique case (ctrl.op)
        emh_pkg::OP_K_C1, emh_pkg::OP_K_C2: k_nxt = mul_p;
        emh_pkg::OP_H_M1, emh_pkg::OP_H_M2: h_nxt = mul_p;
        emh_pkg::OP_H_ABS: begin
          h_nxt   = abs_t + {abs_t[29:0], 2'b00} + emh_pkg::MIX_N;
          k_nxt   = q_r[0];
          q_nxt   = {32'd0, q_r[3:1]};
          blk_nxt = blk_r - 2'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    h_r   <= h_nxt;
    k_r   <= k_nxt;
    q_r   <= q_nxt;
    blk_r <= blk_nxt;
    v6_r  <= v6_nxt;
  end

  assign stat.more_blk = (blk_r != 2'd0);
  assign stat.fin_hash = h_r ^ {16'd0, h_r[31:16]};

endmodule

`default_nettype wire
